// ===== design/jvc_pkg.sv =====
package jvc_pkg;

  localparam int AxisBits   = 16;
  localparam int RegBits    = 15;
  localparam int MagBits    = 15;
  localparam int SpeedBits  = MagBits + 1;
  localparam int LaneProdBits = AxisBits + RegBits;
  localparam int ProdBits   = MagBits + RegBits;
  localparam int SumBits    = 2 * MagBits + 1;
  localparam int RootBits   = 16;
  localparam int RadBits    = 2 * RootBits;
  localparam int NumLanes   = 4;
  localparam int RegIdxBits = 3;

  localparam logic [RegBits-1:0] DeadzoneReset = RegBits'(3277);
  localparam logic [RegBits-1:0] GainReset     = RegBits'(4096);
  localparam logic [RegBits-1:0] LimitReset    = RegBits'(4096);

  typedef enum logic [RegIdxBits-1:0] {
    REG_DEADZONE     = 3'd0,
    REG_GAIN_VX      = 3'd1,
    REG_GAIN_VY      = 3'd2,
    REG_GAIN_OMEGA   = 3'd3,
    REG_GAIN_HEIGHT  = 3'd4,
    REG_MAX_LIN      = 3'd5,
    REG_MAX_ROT      = 3'd6,
    REG_MAX_HEIGHT   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_CHECK,
    S_ROOT,
    S_DIV_START,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [RegBits-1:0] deadzone;
    logic [RegBits-1:0] gain;
    logic [RegBits-1:0] limit;
  } lane_cfg_t;

endpackage

// ===== design/joystick_velocity_conditioner.sv =====
// Joystick velocity conditioner. Each sample transfer carries four signed Q1.15 stick axes
// and the homing and emergency buttons with their partner-ready flags; one result transfer
// of four Q4.12 commands and two one-shot requests follows for each sample, in order.
// Four lanes apply the deadzone and the clamped gain to the axes in the cycle of the input
// transfer. When the planar speed stays within the linear limit, the sample passes from the
// square state through the check state to the done state, where the result waits for the
// output register. Otherwise a bit-serial square root and two bit-serial dividers scale the
// planar pair before the done state. One sample is processed at a time; the next sample is
// taken as soon as the result sits in the output register, even if it is still stalled.
// Configuration registers may be written only while no sample is in flight.
module joystick_velocity_conditioner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [jvc_pkg::RegIdxBits-1:0]      cfg_idx_i,
  input  logic [jvc_pkg::RegBits-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [jvc_pkg::AxisBits-1:0] axis_fwd_i,
  input  logic signed [jvc_pkg::AxisBits-1:0] axis_side_i,
  input  logic signed [jvc_pkg::AxisBits-1:0] axis_turn_i,
  input  logic signed [jvc_pkg::AxisBits-1:0] axis_lift_i,
  input  logic                                home_pressed_i,
  input  logic                                stop_pressed_i,
  input  logic                                home_ready_i,
  input  logic                                stop_ready_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [jvc_pkg::SpeedBits-1:0] speed_fwd_o,
  output logic signed [jvc_pkg::SpeedBits-1:0] speed_side_o,
  output logic signed [jvc_pkg::SpeedBits-1:0] turn_rate_o,
  output logic signed [jvc_pkg::SpeedBits-1:0] lift_rate_o,
  output logic                                home_request_o,
  output logic                                stop_request_o
);

  logic [jvc_pkg::RegBits-1:0] deadzone_q, gain_vx_q, gain_vy_q, gain_omega_q;
  logic [jvc_pkg::RegBits-1:0] gain_height_q, max_lin_q, max_rot_q, max_height_q;

  jvc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            home_latched_q, stop_latched_q;
  logic            in_xfer, out_load, root_start, div_start, clamp;

  logic signed [jvc_pkg::AxisBits-1:0] lane_axis [jvc_pkg::NumLanes];
  jvc_pkg::lane_cfg_t                  lane_cfg  [jvc_pkg::NumLanes];
  logic [jvc_pkg::MagBits-1:0]         lane_mag  [jvc_pkg::NumLanes];
  logic                                lane_neg  [jvc_pkg::NumLanes];
  logic [jvc_pkg::MagBits-1:0]         mag_q     [jvc_pkg::NumLanes];
  logic                                neg_q     [jvc_pkg::NumLanes];
  logic                                home_req_q, stop_req_q;

  logic [2*jvc_pkg::MagBits-1:0]  sq_x_q, sq_y_q;
  logic [2*jvc_pkg::RegBits-1:0]  lim_sq_q;
  logic [jvc_pkg::SumBits-1:0]    sum_sq;
  logic [jvc_pkg::ProdBits-1:0]   prod_x_q, prod_y_q;
  logic [jvc_pkg::RootBits-1:0]   root, div_m_q;
  logic [jvc_pkg::RootBits:0]     root_up;
  logic                           root_exact, root_done;
  logic [jvc_pkg::MagBits-1:0]    quot_x, quot_y;
  logic                           div_done, div_y_done;
  logic signed [jvc_pkg::SpeedBits-1:0] speed [jvc_pkg::NumLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q    <= jvc_pkg::DeadzoneReset;
      gain_vx_q     <= jvc_pkg::GainReset;
      gain_vy_q     <= jvc_pkg::GainReset;
      gain_omega_q  <= jvc_pkg::GainReset;
      gain_height_q <= jvc_pkg::GainReset;
      max_lin_q     <= jvc_pkg::LimitReset;
      max_rot_q     <= jvc_pkg::LimitReset;
      max_height_q  <= jvc_pkg::LimitReset;
    end else if (cfg_we_i) begin
      unique case (jvc_pkg::reg_idx_e'(cfg_idx_i))
        jvc_pkg::REG_DEADZONE:    deadzone_q    <= cfg_data_i;
        jvc_pkg::REG_GAIN_VX:     gain_vx_q     <= cfg_data_i;
        jvc_pkg::REG_GAIN_VY:     gain_vy_q     <= cfg_data_i;
        jvc_pkg::REG_GAIN_OMEGA:  gain_omega_q  <= cfg_data_i;
        jvc_pkg::REG_GAIN_HEIGHT: gain_height_q <= cfg_data_i;
        jvc_pkg::REG_MAX_LIN:     max_lin_q     <= cfg_data_i;
        jvc_pkg::REG_MAX_ROT:     max_rot_q     <= cfg_data_i;
        jvc_pkg::REG_MAX_HEIGHT:  max_height_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lane_axis[0] = axis_fwd_i;
  assign lane_axis[1] = axis_side_i;
  assign lane_axis[2] = axis_turn_i;
  assign lane_axis[3] = axis_lift_i;
  assign lane_cfg[0]  = '{deadzone: deadzone_q, gain: gain_vx_q,     limit: max_lin_q};
  assign lane_cfg[1]  = '{deadzone: deadzone_q, gain: gain_vy_q,     limit: max_lin_q};
  assign lane_cfg[2]  = '{deadzone: deadzone_q, gain: gain_omega_q,  limit: max_rot_q};
  assign lane_cfg[3]  = '{deadzone: deadzone_q, gain: gain_height_q, limit: max_height_q};

  for (genvar i = 0; i < jvc_pkg::NumLanes; i++) begin : g_lane
    jvc_lane u_lane (
      .axis_i (lane_axis[i]),
      .cfg_i  (lane_cfg[i]),
      .mag_o  (lane_mag[i]),
      .neg_o  (lane_neg[i])
    );
  end

  assign sum_sq  = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign clamp   = sum_sq > {1'b0, lim_sq_q};
  assign root_up = {1'b0, root} + {{jvc_pkg::RootBits{1'b0}}, ~root_exact};

  jvc_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i ({1'b0, sum_sq}),
    .done_o     (root_done),
    .root_o     (root),
    .exact_o    (root_exact)
  );

  jvc_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_x_q),
    .divisor_i  (div_m_q),
    .done_o     (div_done),
    .quotient_o (quot_x)
  );

  jvc_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_y_q),
    .divisor_i  (div_m_q),
    .done_o     (div_y_done),
    .quotient_o (quot_y)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jvc_pkg::S_IDLE:      if (in_xfer) state_d = jvc_pkg::S_SQUARE;
      jvc_pkg::S_SQUARE:    state_d = jvc_pkg::S_CHECK;
      jvc_pkg::S_CHECK:     state_d = clamp ? jvc_pkg::S_ROOT : jvc_pkg::S_DONE;
      jvc_pkg::S_ROOT:      if (root_done) state_d = jvc_pkg::S_DIV_START;
      jvc_pkg::S_DIV_START: state_d = jvc_pkg::S_DIV;
      jvc_pkg::S_DIV:       if (div_done && div_y_done) state_d = jvc_pkg::S_DONE;
      jvc_pkg::S_DONE:      if (out_load) state_d = jvc_pkg::S_IDLE;
      default:              state_d = jvc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != jvc_pkg::S_IDLE);
    in_xfer     = in_valid_i && (state_q == jvc_pkg::S_IDLE);
    root_start  = (state_q == jvc_pkg::S_CHECK) && clamp;
    div_start   = (state_q == jvc_pkg::S_DIV_START);
    out_load    = (state_q == jvc_pkg::S_DONE) && (!out_valid_q || !out_stall_i);
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= jvc_pkg::S_IDLE;
      out_valid_q    <= 1'b0;
      home_latched_q <= 1'b0;
      stop_latched_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        home_latched_q <= home_pressed_i && (home_latched_q || home_ready_i);
        stop_latched_q <= stop_pressed_i && (stop_latched_q || stop_ready_i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < jvc_pkg::NumLanes; i++) begin
      speed[i] = neg_q[i] ? -$signed({1'b0, mag_q[i]}) : $signed({1'b0, mag_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < jvc_pkg::NumLanes; i++) begin
        mag_q[i] <= lane_mag[i];
        neg_q[i] <= lane_neg[i];
      end
      home_req_q <= home_pressed_i && !home_latched_q && home_ready_i;
      stop_req_q <= stop_pressed_i && !stop_latched_q && stop_ready_i;
    end
    if (state_q == jvc_pkg::S_SQUARE) begin
      sq_x_q   <= (2*jvc_pkg::MagBits)'(mag_q[0]) * (2*jvc_pkg::MagBits)'(mag_q[0]);
      sq_y_q   <= (2*jvc_pkg::MagBits)'(mag_q[1]) * (2*jvc_pkg::MagBits)'(mag_q[1]);
      lim_sq_q <= (2*jvc_pkg::RegBits)'(max_lin_q) * (2*jvc_pkg::RegBits)'(max_lin_q);
    end
    if (state_q == jvc_pkg::S_CHECK) begin
      prod_x_q <= jvc_pkg::ProdBits'(mag_q[0]) * jvc_pkg::ProdBits'(max_lin_q);
      prod_y_q <= jvc_pkg::ProdBits'(mag_q[1]) * jvc_pkg::ProdBits'(max_lin_q);
    end
    if ((state_q == jvc_pkg::S_ROOT) && root_done) begin
      div_m_q <= root_up[jvc_pkg::RootBits-1:0];
    end
    if ((state_q == jvc_pkg::S_DIV) && div_done) begin
      mag_q[0] <= quot_x;
      mag_q[1] <= quot_y;
    end
    if (out_load) begin
      speed_fwd_o    <= speed[0];
      speed_side_o   <= speed[1];
      turn_rate_o    <= speed[2];
      lift_rate_o    <= speed[3];
      home_request_o <= home_req_q;
      stop_request_o <= stop_req_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // A scaled planar component never exceeds the linear limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == jvc_pkg::S_DIV) && div_done) |->
      (quot_x <= max_lin_q) && (quot_y <= max_lin_q))
    else $error("planar component above linear limit");

  // The root is the floor of the square root of the planar sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == jvc_pkg::S_ROOT) && root_done) |->
      ((34'(root) * 34'(root)) <= 34'(sum_sq)) &&
      ((34'(root_up) * 34'(root_up)) >= 34'(sum_sq)))
    else $error("square root out of range");

  // Both dividers run in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done == div_y_done)
    else $error("dividers out of step");

  // A result only appears after the sample finished processing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == jvc_pkg::S_DONE))
    else $error("result without finished sample");

endmodule

// ===== design/jvc_lane.sv =====
module jvc_lane (
  input  logic signed [jvc_pkg::AxisBits-1:0] axis_i,
  input  jvc_pkg::lane_cfg_t                  cfg_i,
  output logic        [jvc_pkg::MagBits-1:0]  mag_o,
  output logic                                neg_o
);

  logic                                  neg;
  logic [jvc_pkg::AxisBits-1:0]          abs_v;
  logic [jvc_pkg::RegBits-1:0]           gain_eff;
  logic                                  in_dz;
  logic [jvc_pkg::LaneProdBits-1:0]      prod;
  logic [jvc_pkg::LaneProdBits-1:0]      rnd;

  always_comb begin
    neg      = axis_i[jvc_pkg::AxisBits-1];
    abs_v    = neg ? (~axis_i + 1'b1) : axis_i;
    gain_eff = (cfg_i.gain > cfg_i.limit) ? cfg_i.limit : cfg_i.gain;
    in_dz    = jvc_pkg::LaneProdBits'(abs_v) < jvc_pkg::LaneProdBits'(cfg_i.deadzone);
    prod     = jvc_pkg::LaneProdBits'(abs_v) * jvc_pkg::LaneProdBits'(gain_eff);
    rnd      = prod + (jvc_pkg::LaneProdBits'(1) << (jvc_pkg::AxisBits - 2));
    mag_o    = in_dz ? '0 : rnd[jvc_pkg::AxisBits-1 +: jvc_pkg::MagBits];
    neg_o    = neg & ~in_dz;
  end

endmodule

// ===== design/jvc_isqrt.sv =====
module jvc_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [jvc_pkg::RadBits-1:0]   radicand_i,
  output logic                          done_o,
  output logic [jvc_pkg::RootBits-1:0]  root_o,
  output logic                          exact_o
);

  localparam int RemBits = jvc_pkg::RootBits + 2;
  localparam int TryBits = RemBits + 2;
  localparam int CntBits = $clog2(jvc_pkg::RootBits);
  localparam logic [CntBits-1:0] CntLast = CntBits'(jvc_pkg::RootBits - 1);

  logic                         busy_q, done_q;
  logic [CntBits-1:0]           cnt_q;
  logic [jvc_pkg::RadBits-1:0]  rad_q;
  logic [RemBits-1:0]           rem_q, rem_d;
  logic [jvc_pkg::RootBits-1:0] root_q;
  logic [TryBits-1:0]           rem_t, trial;
  logic                         ge;

  always_comb begin
    rem_t = {rem_q, rad_q[jvc_pkg::RadBits-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    ge    = rem_t >= trial;
    rem_d = ge ? RemBits'(rem_t - trial) : RemBits'(rem_t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntLast);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_d;
      root_q <= {root_q[jvc_pkg::RootBits-2:0], ge};
    end
  end

  assign done_o  = done_q;
  assign root_o  = root_q;
  assign exact_o = (rem_q == '0);

endmodule

// ===== design/jvc_div.sv =====
module jvc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [jvc_pkg::ProdBits-1:0]  dividend_i,
  input  logic [jvc_pkg::RootBits-1:0]  divisor_i,
  output logic                          done_o,
  output logic [jvc_pkg::MagBits-1:0]   quotient_o
);

  localparam int QBits   = jvc_pkg::MagBits;
  localparam int HiBits  = jvc_pkg::ProdBits - QBits;
  localparam int CntBits = $clog2(QBits);
  localparam logic [CntBits-1:0] CntLast = CntBits'(QBits - 1);

  logic                         busy_q, done_q;
  logic [CntBits-1:0]           cnt_q;
  logic [jvc_pkg::RootBits-1:0] rem_q, div_q, rem_d;
  logic [QBits-1:0]             low_q;
  logic [jvc_pkg::RootBits:0]   rem_t;
  logic                         ge;

  always_comb begin
    rem_t = {rem_q, low_q[QBits-1]};
    ge    = rem_t >= {1'b0, div_q};
    rem_d = ge ? jvc_pkg::RootBits'(rem_t - {1'b0, div_q}) : jvc_pkg::RootBits'(rem_t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntLast);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // The dividend is below divisor times 2^QBits, so the high part starts below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= jvc_pkg::RootBits'(dividend_i[jvc_pkg::ProdBits-1 -: HiBits]);
      low_q <= dividend_i[QBits-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[QBits-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = low_q;

endmodule

// ===== dv/tb_joystick_velocity_conditioner.sv =====
`timescale 1ns / 100ps

module tb_joystick_velocity_conditioner;

  localparam int CycleLimit = 400000;
  localparam int LongHoldCycles = 300;
  localparam int SettleCycles = 60;

  typedef struct packed {
    logic signed [jvc_pkg::AxisBits-1:0] fwd;
    logic signed [jvc_pkg::AxisBits-1:0] side;
    logic signed [jvc_pkg::AxisBits-1:0] turn;
    logic signed [jvc_pkg::AxisBits-1:0] lift;
    logic home;
    logic stop;
    logic home_rdy;
    logic stop_rdy;
  } sample_t;

  typedef struct packed {
    logic signed [jvc_pkg::SpeedBits-1:0] fwd;
    logic signed [jvc_pkg::SpeedBits-1:0] side;
    logic signed [jvc_pkg::SpeedBits-1:0] turn;
    logic signed [jvc_pkg::SpeedBits-1:0] lift;
    logic home_req;
    logic stop_req;
  } command_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [jvc_pkg::RegIdxBits-1:0] cfg_idx = '0;
  logic [jvc_pkg::RegBits-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t drive_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  command_t dut_command;

  sample_t pending_samples[$];
  command_t expected_commands[$];
  logic [jvc_pkg::RegBits-1:0] cfg_model[8];
  logic home_latch = 1'b0;
  logic stop_latch = 1'b0;
  logic idle_on = 1'b1;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int stall_left = 0;
  int send_gap = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  joystick_velocity_conditioner u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .axis_fwd_i    (drive_sample.fwd),
    .axis_side_i   (drive_sample.side),
    .axis_turn_i   (drive_sample.turn),
    .axis_lift_i   (drive_sample.lift),
    .home_pressed_i(drive_sample.home),
    .stop_pressed_i(drive_sample.stop),
    .home_ready_i  (drive_sample.home_rdy),
    .stop_ready_i  (drive_sample.stop_rdy),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .speed_fwd_o   (dut_command.fwd),
    .speed_side_o  (dut_command.side),
    .turn_rate_o   (dut_command.turn),
    .lift_rate_o   (dut_command.lift),
    .home_request_o(dut_command.home_req),
    .stop_request_o(dut_command.stop_req)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint gain_within(logic [jvc_pkg::RegBits-1:0] gain,
                                         logic [jvc_pkg::RegBits-1:0] limit);
    return (gain > limit) ? longint'(limit) : longint'(gain);
  endfunction

  function automatic longint axis_speed(logic signed [jvc_pkg::AxisBits-1:0] axis,
                                        logic [jvc_pkg::RegBits-1:0] deadzone,
                                        longint gain);
    longint a;
    longint dz;
    longint mag;
    longint r;
    a = longint'(axis);
    dz = longint'(deadzone);
    if (a < dz && a > -dz) return 0;
    mag = (a < 0) ? -a : a;
    r = (mag * gain + (longint'(1) << (jvc_pkg::AxisBits - 2))) >>> (jvc_pkg::AxisBits - 1);
    return (a < 0) ? -r : r;
  endfunction

  function automatic longint ceil_root(longint s);
    longint r;
    longint t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= s) r = t;
    end
    if (r * r < s) r++;
    return r;
  endfunction

  function automatic longint shrink_to_limit(longint v, longint limit, longint m);
    longint r;
    r = (((v < 0) ? -v : v) * limit) / m;
    return (v < 0) ? -r : r;
  endfunction

  function automatic command_t predict_command(sample_t s);
    command_t c;
    longint dz_gain_lim;
    longint vx;
    longint vy;
    longint om;
    longint hr;
    longint m;
    dz_gain_lim = longint'(cfg_model[jvc_pkg::REG_MAX_LIN]);
    vx = axis_speed(s.fwd, cfg_model[jvc_pkg::REG_DEADZONE],
                    gain_within(cfg_model[jvc_pkg::REG_GAIN_VX],
                                cfg_model[jvc_pkg::REG_MAX_LIN]));
    vy = axis_speed(s.side, cfg_model[jvc_pkg::REG_DEADZONE],
                    gain_within(cfg_model[jvc_pkg::REG_GAIN_VY],
                                cfg_model[jvc_pkg::REG_MAX_LIN]));
    om = axis_speed(s.turn, cfg_model[jvc_pkg::REG_DEADZONE],
                    gain_within(cfg_model[jvc_pkg::REG_GAIN_OMEGA],
                                cfg_model[jvc_pkg::REG_MAX_ROT]));
    hr = axis_speed(s.lift, cfg_model[jvc_pkg::REG_DEADZONE],
                    gain_within(cfg_model[jvc_pkg::REG_GAIN_HEIGHT],
                                cfg_model[jvc_pkg::REG_MAX_HEIGHT]));
    if (vx * vx + vy * vy > dz_gain_lim * dz_gain_lim) begin
      m = ceil_root(vx * vx + vy * vy);
      vx = shrink_to_limit(vx, dz_gain_lim, m);
      vy = shrink_to_limit(vy, dz_gain_lim, m);
    end
    c.fwd = jvc_pkg::SpeedBits'(vx);
    c.side = jvc_pkg::SpeedBits'(vy);
    c.turn = jvc_pkg::SpeedBits'(om);
    c.lift = jvc_pkg::SpeedBits'(hr);
    c.home_req = 1'b0;
    c.stop_req = 1'b0;
    if (s.home) begin
      if (!home_latch && s.home_rdy) begin
        c.home_req = 1'b1;
        home_latch = 1'b1;
      end
    end else begin
      home_latch = 1'b0;
    end
    if (s.stop) begin
      if (!stop_latch && s.stop_rdy) begin
        c.stop_req = 1'b1;
        stop_latch = 1'b1;
      end
    end else begin
      stop_latch = 1'b0;
    end
    return c;
  endfunction

  function automatic logic signed [jvc_pkg::AxisBits-1:0] random_axis(int deadzone);
    int v;
    case ($urandom_range(0, 9))
      0: v = -32768;
      1: v = 32767;
      2, 3: begin
        v = deadzone + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      4, 5, 6: v = int'($urandom_range(0, 65535)) - 32768;
      default: begin
        v = int'($urandom_range(20000, 32767));
        if ($urandom_range(0, 1) != 0) v = -v - 1;
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return jvc_pkg::AxisBits'(v);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int dz;
    dz = int'(cfg_model[jvc_pkg::REG_DEADZONE]);
    s.fwd = random_axis(dz);
    s.side = random_axis(dz);
    s.turn = random_axis(dz);
    s.lift = random_axis(dz);
    s.home = 1'($urandom_range(0, 1));
    s.stop = 1'($urandom_range(0, 1));
    s.home_rdy = ($urandom_range(0, 3) != 0);
    s.stop_rdy = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  task automatic add_sample(int fwd, int side, int turn, int lift,
                            bit hp, bit sp, bit hr, bit sr);
    sample_t s;
    s.fwd = jvc_pkg::AxisBits'(fwd);
    s.side = jvc_pkg::AxisBits'(side);
    s.turn = jvc_pkg::AxisBits'(turn);
    s.lift = jvc_pkg::AxisBits'(lift);
    s.home = hp;
    s.stop = sp;
    s.home_rdy = hr;
    s.stop_rdy = sr;
    pending_samples.push_back(s);
  endtask

  task automatic write_reg(jvc_pkg::reg_idx_e idx, logic [jvc_pkg::RegBits-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    cfg_model[idx] = value;
  endtask

  task automatic write_config(int dz, int gvx, int gvy, int gom, int ght,
                              int mlin, int mrot, int mht);
    write_reg(jvc_pkg::REG_DEADZONE, jvc_pkg::RegBits'(dz));
    write_reg(jvc_pkg::REG_GAIN_VX, jvc_pkg::RegBits'(gvx));
    write_reg(jvc_pkg::REG_GAIN_VY, jvc_pkg::RegBits'(gvy));
    write_reg(jvc_pkg::REG_GAIN_OMEGA, jvc_pkg::RegBits'(gom));
    write_reg(jvc_pkg::REG_GAIN_HEIGHT, jvc_pkg::RegBits'(ght));
    write_reg(jvc_pkg::REG_MAX_LIN, jvc_pkg::RegBits'(mlin));
    write_reg(jvc_pkg::REG_MAX_ROT, jvc_pkg::RegBits'(mrot));
    write_reg(jvc_pkg::REG_MAX_HEIGHT, jvc_pkg::RegBits'(mht));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid || expected_commands.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) expected_commands.push_back(predict_command(drive_sample));
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 5);
        if (send_gap > 0 || pending_samples.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          drive_sample <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = LongHoldCycles - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    command_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_commands.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        want = expected_commands.pop_front();
        if (dut_command.fwd !== want.fwd)
          report_mismatch("speed_fwd", int'(dut_command.fwd), int'(want.fwd));
        if (dut_command.side !== want.side)
          report_mismatch("speed_side", int'(dut_command.side), int'(want.side));
        if (dut_command.turn !== want.turn)
          report_mismatch("turn_rate", int'(dut_command.turn), int'(want.turn));
        if (dut_command.lift !== want.lift)
          report_mismatch("lift_rate", int'(dut_command.lift), int'(want.lift));
        if (dut_command.home_req !== want.home_req)
          report_mismatch("home_request", int'(dut_command.home_req), int'(want.home_req));
        if (dut_command.stop_req !== want.stop_req)
          report_mismatch("stop_request", int'(dut_command.stop_req), int'(want.stop_req));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cfg_model[jvc_pkg::REG_DEADZONE] = jvc_pkg::DeadzoneReset;
    cfg_model[jvc_pkg::REG_GAIN_VX] = jvc_pkg::GainReset;
    cfg_model[jvc_pkg::REG_GAIN_VY] = jvc_pkg::GainReset;
    cfg_model[jvc_pkg::REG_GAIN_OMEGA] = jvc_pkg::GainReset;
    cfg_model[jvc_pkg::REG_GAIN_HEIGHT] = jvc_pkg::GainReset;
    cfg_model[jvc_pkg::REG_MAX_LIN] = jvc_pkg::LimitReset;
    cfg_model[jvc_pkg::REG_MAX_ROT] = jvc_pkg::LimitReset;
    cfg_model[jvc_pkg::REG_MAX_HEIGHT] = jvc_pkg::LimitReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    add_sample(0, 0, 0, 0, 0, 0, 0, 0);
    add_sample(32767, 0, -32768, 32767, 0, 0, 1, 1);
    add_sample(-32768, -32768, -32768, -32768, 0, 0, 0, 0);
    add_sample(3276, -3276, 3277, -3277, 0, 0, 1, 1);
    add_sample(32767, 32767, -32767, 1, 0, 0, 0, 0);
    add_sample(-32768, 32767, 16000, -16000, 0, 0, 1, 1);
    add_sample(16000, -20000, 100, -100, 0, 0, 0, 0);
    add_sample(-1, 1, 32766, -32767, 0, 0, 1, 1);
    add_sample(0, 0, 0, 0, 1, 0, 0, 1);
    add_sample(0, 0, 0, 0, 1, 0, 1, 1);
    add_sample(0, 0, 0, 0, 1, 0, 1, 1);
    add_sample(0, 0, 0, 0, 0, 0, 1, 1);
    add_sample(0, 0, 0, 0, 1, 0, 1, 1);
    add_sample(0, 0, 0, 0, 0, 1, 1, 0);
    add_sample(0, 0, 0, 0, 0, 1, 1, 1);
    add_sample(0, 0, 0, 0, 0, 1, 1, 1);
    add_sample(0, 0, 0, 0, 0, 0, 1, 1);
    add_sample(0, 0, 0, 0, 0, 1, 1, 1);
    add_sample(20000, 25000, -5000, 7000, 1, 1, 1, 1);
    add_sample(-25000, 20000, 5000, -7000, 1, 1, 1, 1);
    add_sample(-25000, -20000, 0, 0, 0, 0, 0, 0);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_config($urandom_range(0, 6000), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 32767));
        1: write_config(0, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        2: write_config($urandom_range(0, 6000), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), 0, 0, 0);
        3: write_config(32767, $urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 32767),
                        32767, 32767, 32767);
        4: write_config(1, 32767, 32767, 32767, 32767, $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 32767));
        5: write_config($urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 8000),
                        $urandom_range(0, 8000), $urandom_range(0, 8000));
        6: write_config($urandom_range(0, 6000), $urandom_range(0, 2000),
                        $urandom_range(0, 2000), $urandom_range(0, 2000),
                        $urandom_range(0, 2000), 32767, 32767, 32767);
        default: write_config($urandom_range(0, 32767), $urandom_range(0, 32767),
                              $urandom_range(0, 32767), $urandom_range(0, 32767),
                              $urandom_range(0, 32767), $urandom_range(0, 32767),
                              $urandom_range(0, 32767), $urandom_range(0, 32767));
      endcase
      if (phase == 1) hold_requests <= hold_requests + 1;
      if (phase == 7) idle_on <= 1'b0;
      repeat (80) pending_samples.push_back(random_sample());
      wait_idle();
    end

    if (mismatch_count == 0 && expected_commands.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
